// ----- sv/bond_price_and_duration_macros.svh -----
// ----------------------------------------------------------------------------
// Bond price and duration assertion macros
// Shared property wrappers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOND_PRICE_AND_DURATION_MACROS_SVH
`define BOND_PRICE_AND_DURATION_MACROS_SVH

// Same-cycle implication
`define BPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Bond price and duration package
// Widths, constants, command and status types, and the Q.32 product rounding.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_YEARS  = 64;

    localparam int AMT_W      = 40;
    localparam int YLD_W      = 32;
    localparam int MAT_W      = 23;
    localparam int DUR_W      = 32;
    localparam int Q_W        = 33;
    localparam int N_W        = $clog2(MAX_YEARS + 1);
    localparam int SUM_W      = AMT_W + $clog2(MAX_YEARS + 2);
    localparam int NUM_W      = SUM_W + 7;
    localparam int DVD_W      = (NUM_W + 16 > 65) ? NUM_W + 16 : 65;
    localparam int DVS_W      = SUM_W;
    localparam int SQ_W       = 64;
    localparam int DIV_STEPS  = DVD_W;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int FIDX_W     = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

    localparam logic [Q_W-1:0]   ONE_Q      = Q_W'(64'h1_0000_0000);
    localparam logic [Q_W-1:0]   YIELD_STEP = Q_W'(42949673);
    localparam logic [AMT_W-1:0] AMT_MAX    = {AMT_W{1'b1}};
    localparam logic [DUR_W-1:0] DUR_MAX    = {DUR_W{1'b1}};
    localparam logic [31:0]      MAT_LIM    = 32'(MAX_YEARS) << FRAC_BITS;

    localparam logic [AMT_W-1:0] FACE_RST   = AMT_W'(65536000);
    localparam logic [AMT_W-1:0] COUPON_RST = AMT_W'(6553600);
    localparam logic [MAT_W-1:0] MAT_RST    = MAT_W'(655360);

    typedef enum logic [1:0] {
        REG_FACE   = 2'd0,
        REG_COUPON = 2'd1,
        REG_MAT    = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RECIP_INIT,
        OP_DIV_STEP,
        OP_RECIP_WB,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_WB,
        OP_MUL_VF,
        OP_VF_WB,
        OP_MUL_D,
        OP_D_WB,
        OP_SCL_LO,
        OP_SCL_HI,
        OP_SCL_ADD,
        OP_MUL_P,
        OP_P_WB,
        OP_PRICE_WB,
        OP_DUR_INIT,
        OP_DUR_WB
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pass;
        logic amt_face;
    } cmd_t;

    typedef struct packed {
        logic [N_W-1:0]       n;
        logic [FRAC_BITS-1:0] f;
    } sts_t;

    function automatic logic [Q_W-1:0] qmul_wb(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b,
                                               input logic [63:0]    prod);
        logic [64:0] rnd;
        rnd = {1'b0, prod} + 65'h8000_0000;
        if (a[Q_W-1]) begin
            return b;
        end else if (b[Q_W-1]) begin
            return a;
        end
        return rnd[64:32];
    endfunction

endpackage

// ----- sv/bond_price_and_duration.sv -----
// ----------------------------------------------------------------------------
// Bond price and modified duration
// Prices a bond at one yield and at yield plus 0.01, returns price and duration.
// ----------------------------------------------------------------------------
// The 32-step square-root unit, the 70-step divider and the shared multiplier do the
// work; maturity is clamped to MAX_YEARS whole years.
// One transaction is worked at a time; the next is taken once the result is registered.
// Synchronous active-low reset clears control and loads the register defaults.
module bond_price_and_duration import bpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] yield_rate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [39:0] bond_price, [71:40] modified_duration
    output logic [0:0]  m_tuser,   // [0] price_zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "bond_price_and_duration_macros.svh"

    logic [AMT_W-1:0] face_reg,   face_next;
    logic [AMT_W-1:0] coupon_reg, coupon_next;
    logic [MAT_W-1:0] mat_reg,    mat_next;
    reg_idx_t         idx;
    logic             wr_en;
    cmd_t             cmd;
    sts_t             sts;
    logic [AMT_W-1:0] bond_price;
    logic [DUR_W-1:0] modified_duration;
    logic             price_zero;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        face_next   = face_reg;
        coupon_next = coupon_reg;
        mat_next    = mat_reg;
        prdata      = '0;
        unique case (idx)
            REG_FACE: begin
                prdata = 64'(face_reg);
                if (wr_en) begin
                    face_next = pwdata[AMT_W-1:0];
                end
            end
            REG_COUPON: begin
                prdata = 64'(coupon_reg);
                if (wr_en) begin
                    coupon_next = pwdata[AMT_W-1:0];
                end
            end
            REG_MAT: begin
                prdata = 64'(mat_reg);
                if (wr_en) begin
                    mat_next = pwdata[MAT_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_reg   <= FACE_RST;
            coupon_reg <= COUPON_RST;
            mat_reg    <= MAT_RST;
        end else begin
            face_reg   <= face_next;
            coupon_reg <= coupon_next;
            mat_reg    <= mat_next;
        end
    end

    bpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpd_datapath u_datapath (
        .aclk              (aclk),
        .cmd               (cmd),
        .yield_rate        (s_tdata),
        .face_value        (face_reg),
        .coupon_amount     (coupon_reg),
        .years_to_maturity (mat_reg),
        .sts               (sts),
        .bond_price        (bond_price),
        .modified_duration (modified_duration),
        .price_zero        (price_zero)
    );

    assign m_tdata    = {modified_duration, bond_price};
    assign m_tuser[0] = price_zero;

    `BPD_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `BPD_ASSERT_IMP(a_zero_price_out, m_tvalid && m_tuser[0], m_tdata == '0, "zero price not clean")
    `BPD_ASSERT_IMP(a_idle_or_busy, m_tvalid && !m_tready && !s_tready, $stable(m_tdata) || $rose(m_tvalid), "result changed while held")

endmodule

// ----- sv/bpd_datapath.sv -----
// ----------------------------------------------------------------------------
// Bond price and duration datapath
// Shared multiplier, restoring divider, square-root unit and accumulators.
// ----------------------------------------------------------------------------
module bpd_datapath import bpd_pkg::*; (
    input  logic             aclk,
    input  cmd_t             cmd,
    input  logic [YLD_W-1:0] yield_rate,
    input  logic [AMT_W-1:0] face_value,
    input  logic [AMT_W-1:0] coupon_amount,
    input  logic [MAT_W-1:0] years_to_maturity,
    output sts_t             sts,
    output logic [AMT_W-1:0] bond_price,
    output logic [DUR_W-1:0] modified_duration,
    output logic             price_zero
);

    logic [YLD_W-1:0] y_reg,   y_next;
    logic [Q_W-1:0]   v_reg,   v_next;
    logic [Q_W-1:0]   r_reg,   r_next;
    logic [Q_W-1:0]   vf_reg,  vf_next;
    logic [Q_W-1:0]   p_reg,   p_next;
    logic [Q_W-1:0]   d_reg,   d_next;
    logic [63:0]      prod_reg, prod_next;
    logic [Q_W-1:0]   tmp_reg, tmp_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] p1_reg,  p1_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0]  sx_reg,  sx_next;
    logic [SQ_W-1:0]  sres_reg, sres_next;
    logic [SQ_W-1:0]  sbit_reg, sbit_next;
    logic [AMT_W-1:0] price_reg, price_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic             zero_reg, zero_next;

    logic [31:0]      mat;
    logic [31:0]      mul_a, mul_b;
    logic [AMT_W-1:0] amt;
    logic [Q_W-1:0]   ytmp;
    logic [DVS_W:0]   rem_sh, rem_dif;
    logic             ge;
    logic             rnd_up;
    logic [SQ_W-1:0]  sq_try;
    logic [AMT_W:0]   term;
    logic [SUM_W-1:0] diff;
    logic [NUM_W-1:0] num;
    logic [64:0]      rnd_sum;
    logic [DUR_W:0]   qr;

    assign mat   = ({9'b0, years_to_maturity} > MAT_LIM) ? MAT_LIM : {9'b0, years_to_maturity};
    assign sts.n = N_W'(mat >> FRAC_BITS);
    assign sts.f = mat[FRAC_BITS-1:0];

    assign amt     = cmd.amt_face ? face_value : coupon_amount;
    assign ytmp    = cmd.pass ? ({1'b0, y_reg} + YIELD_STEP) : {1'b0, y_reg};
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rnd_up  = {rem_reg, 1'b0} >= {1'b0, dvs_reg};
    assign sq_try  = sres_reg + sbit_reg;
    assign term    = d_reg[Q_W-1] ? {1'b0, amt}
                                  : ({1'b0, prod_reg[AMT_W-1:0]} + (AMT_W+1)'(tmp_reg));
    assign diff    = (p1_reg > sum_reg) ? (p1_reg - sum_reg) : '0;
    // 100 = 64 + 32 + 4
    assign num     = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2);
    assign rnd_sum = {1'b0, prod_reg} + 65'h8000_0000;
    assign qr      = {1'b0, dvd_reg[DUR_W-1:0]} + (DUR_W+1)'(rnd_up);

    always_comb begin
        mul_a = vf_reg[31:0];
        mul_b = r_reg[31:0];
        unique case (cmd.op)
            OP_MUL_D: begin
                mul_a = vf_reg[31:0];
                mul_b = p_reg[31:0];
            end
            OP_MUL_P: begin
                mul_a = p_reg[31:0];
                mul_b = v_reg[31:0];
            end
            OP_SCL_LO: begin
                mul_a = amt[31:0];
                mul_b = d_reg[31:0];
            end
            OP_SCL_HI: begin
                mul_a = 32'(amt[AMT_W-1:32]);
                mul_b = d_reg[31:0];
            end
            default: begin
                mul_a = vf_reg[31:0];
                mul_b = r_reg[31:0];
            end
        endcase
    end

    always_comb begin
        y_next     = y_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        vf_next    = vf_reg;
        p_next     = p_reg;
        d_next     = d_reg;
        prod_next  = mul_a * mul_b;
        tmp_next   = tmp_reg;
        sum_next   = sum_reg;
        p1_next    = p1_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        sx_next    = sx_reg;
        sres_next  = sres_reg;
        sbit_next  = sbit_reg;
        price_next = price_reg;
        dur_next   = dur_reg;
        zero_next  = zero_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                y_next = yield_rate;
            end
            OP_RECIP_INIT: begin
                dvd_next = DVD_W'(1) << 64;
                dvs_next = DVS_W'({1'b0, ONE_Q} + {1'b0, ytmp});
                rem_next = '0;
            end
            OP_DIV_STEP: begin
                dvd_next = {dvd_reg[DVD_W-2:0], ge};
                rem_next = ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            end
            OP_RECIP_WB: begin
                v_next   = dvd_reg[Q_W-1:0] + Q_W'(rnd_up);
                r_next   = dvd_reg[Q_W-1:0] + Q_W'(rnd_up);
                vf_next  = ONE_Q;
                p_next   = ONE_Q;
                sum_next = '0;
            end
            OP_SQRT_INIT: begin
                sx_next   = {r_reg[31:0], 32'b0};
                sres_next = '0;
                sbit_next = SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP: begin
                if (sx_reg >= sq_try) begin
                    sx_next   = sx_reg - sq_try;
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            OP_SQRT_WB: begin
                r_next = r_reg[Q_W-1] ? ONE_Q
                                      : (sres_reg[Q_W-1:0] + Q_W'(sx_reg > sres_reg));
            end
            OP_VF_WB: begin
                vf_next = qmul_wb(vf_reg, r_reg, prod_reg);
            end
            OP_D_WB: begin
                d_next = qmul_wb(vf_reg, p_reg, prod_reg);
            end
            OP_SCL_HI: begin
                tmp_next = rnd_sum[64:32];
            end
            OP_SCL_ADD: begin
                sum_next = sum_reg + SUM_W'(term);
            end
            OP_P_WB: begin
                p_next = qmul_wb(p_reg, v_reg, prod_reg);
            end
            OP_PRICE_WB: begin
                p1_next = sum_reg;
            end
            OP_DUR_INIT: begin
                dvd_next = DVD_W'(num) << 16;
                dvs_next = p1_reg;
                rem_next = '0;
            end
            OP_DUR_WB: begin
                zero_next  = (p1_reg == '0);
                price_next = (p1_reg > SUM_W'(AMT_MAX)) ? AMT_MAX : p1_reg[AMT_W-1:0];
                if (p1_reg == '0) begin
                    dur_next = '0;
                end else if (|dvd_reg[DVD_W-1:DUR_W]) begin
                    dur_next = DUR_MAX;
                end else begin
                    dur_next = qr[DUR_W] ? DUR_MAX : qr[DUR_W-1:0];
                end
            end
            default: begin
                y_next = y_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        y_reg     <= y_next;
        v_reg     <= v_next;
        r_reg     <= r_next;
        vf_reg    <= vf_next;
        p_reg     <= p_next;
        d_reg     <= d_next;
        prod_reg  <= prod_next;
        tmp_reg   <= tmp_next;
        sum_reg   <= sum_next;
        p1_reg    <= p1_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        sx_reg    <= sx_next;
        sres_reg  <= sres_next;
        sbit_reg  <= sbit_next;
        price_reg <= price_next;
        dur_reg   <= dur_next;
        zero_reg  <= zero_next;
    end

    assign bond_price        = price_reg;
    assign modified_duration = dur_reg;
    assign price_zero        = zero_reg;

endmodule

// ----- sv/bpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bond price and duration controller
// Sequences the two price passes and the duration division, owns the handshakes.
// ----------------------------------------------------------------------------
module bpd_ctrl import bpd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_RECIP_INIT = 20'h00002,
        S_RECIP      = 20'h00004,
        S_RECIP_WB   = 20'h00008,
        S_SQ_INIT    = 20'h00010,
        S_SQ         = 20'h00020,
        S_SQ_WB      = 20'h00040,
        S_VF_MUL     = 20'h00080,
        S_VF_WB      = 20'h00100,
        S_D_MUL      = 20'h00200,
        S_D_WB       = 20'h00400,
        S_SC_LO      = 20'h00800,
        S_SC_HI      = 20'h01000,
        S_SC_ADD     = 20'h02000,
        S_P_MUL      = 20'h04000,
        S_P_WB       = 20'h08000,
        S_PRICE      = 20'h10000,
        S_DUR_INIT   = 20'h20000,
        S_DUR        = 20'h40000,
        S_DUR_WB     = 20'h80000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [FIDX_W-1:0] jidx_reg,  jidx_next;
    logic [N_W-1:0]    k_reg,     k_next;
    logic              face_reg,  face_next;
    logic              pass_reg,  pass_next;
    logic              mvalid_reg, mvalid_next;
    logic              out_free;
    logic              last_k;

    assign out_free = !mvalid_reg || m_tready;
    assign last_k   = (k_reg == sts.n);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        jidx_next   = jidx_reg;
        k_next      = k_reg;
        face_next   = face_reg;
        pass_next   = pass_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '{op: OP_NONE, pass: pass_reg, amt_face: face_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    pass_next  = 1'b0;
                    state_next = S_RECIP_INIT;
                end
            end
            S_RECIP_INIT: begin
                cmd.op     = OP_RECIP_INIT;
                cnt_next   = '0;
                state_next = S_RECIP;
            end
            S_RECIP: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_RECIP_WB;
                end
            end
            S_RECIP_WB: begin
                cmd.op     = OP_RECIP_WB;
                jidx_next  = FIDX_W'(FRAC_BITS - 1);
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = S_SQ_WB;
                end
            end
            S_SQ_WB, S_VF_WB: begin
                cmd.op = (state_reg == S_SQ_WB) ? OP_SQRT_WB : OP_VF_WB;
                if (state_reg == S_SQ_WB && sts.f[jidx_reg]) begin
                    state_next = S_VF_MUL;
                end else if (jidx_reg == '0) begin
                    k_next     = '0;
                    state_next = S_D_MUL;
                end else begin
                    jidx_next  = jidx_reg - 1'b1;
                    state_next = S_SQ_INIT;
                end
            end
            S_VF_MUL: begin
                cmd.op     = OP_MUL_VF;
                state_next = S_VF_WB;
            end
            S_D_MUL: begin
                cmd.op     = OP_MUL_D;
                state_next = S_D_WB;
            end
            S_D_WB: begin
                cmd.op = OP_D_WB;
                if (k_reg != '0 || sts.f != '0) begin
                    face_next  = 1'b0;
                    state_next = S_SC_LO;
                end else if (last_k) begin
                    face_next  = 1'b1;
                    state_next = S_SC_LO;
                end else begin
                    state_next = S_P_MUL;
                end
            end
            S_SC_LO: begin
                cmd.op     = OP_SCL_LO;
                state_next = S_SC_HI;
            end
            S_SC_HI: begin
                cmd.op     = OP_SCL_HI;
                state_next = S_SC_ADD;
            end
            S_SC_ADD: begin
                cmd.op = OP_SCL_ADD;
                if (last_k && !face_reg) begin
                    face_next  = 1'b1;
                    state_next = S_SC_LO;
                end else if (last_k) begin
                    state_next = pass_reg ? S_DUR_INIT : S_PRICE;
                end else begin
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL: begin
                cmd.op     = OP_MUL_P;
                state_next = S_P_WB;
            end
            S_P_WB: begin
                cmd.op     = OP_P_WB;
                k_next     = k_reg + 1'b1;
                state_next = S_D_MUL;
            end
            S_PRICE: begin
                cmd.op     = OP_PRICE_WB;
                pass_next  = 1'b1;
                state_next = S_RECIP_INIT;
            end
            S_DUR_INIT: begin
                cmd.op     = OP_DUR_INIT;
                cnt_next   = '0;
                state_next = S_DUR;
            end
            S_DUR: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_DUR_WB;
                end
            end
            S_DUR_WB: begin
                if (out_free) begin
                    cmd.op      = OP_DUR_WB;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            jidx_reg   <= '0;
            k_reg      <= '0;
            face_reg   <= 1'b0;
            pass_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            jidx_reg   <= jidx_next;
            k_reg      <= k_next;
            face_reg   <= face_next;
            pass_reg   <= pass_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

// ----- verif/tb_bond_price_and_duration.sv -----
// ----------------------------------------------------------------------------
// Bond price and duration testbench
// Writes several register settings over APB and streams yields into the block.
// Each accepted yield is priced by a bit-exact fixed-point model held here, and
// every returned price, duration and zero-price flag is checked in order.
// ----------------------------------------------------------------------------
module tb_bond_price_and_duration;
    import bpd_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    typedef struct {
        logic [39:0] price;
        logic [31:0] duration;
        logic        zero;
    } valuation_t;

    logic [39:0] face_reg;
    logic [39:0] coupon_reg;
    logic [22:0] maturity_reg;

    logic [31:0] yield_q[$];
    valuation_t  valuation_q[$];
    int          mismatches;
    bit          s_fire;
    bit          m_fire;
    int          s_gap;
    int          m_stall;
    bit          no_idle;

    bond_price_and_duration i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
        if (a >= 64'h1_0000_0000) return b;
        if (b >= 64'h1_0000_0000) return a;
        return (a * b + 64'h8000_0000) >> 32;
    endfunction

    function automatic logic [63:0] amount_scale(logic [63:0] a, logic [63:0] d);
        if (d >= 64'h1_0000_0000) return a;
        return (a >> 32) * d + (((a & 64'hFFFF_FFFF) * d + 64'h8000_0000) >> 32);
    endfunction

    function automatic logic [63:0] q32_root(logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        if (v >= 64'h1_0000_0000) return 64'h1_0000_0000;
        x = v << 32;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (x > res) res++;
        return res;
    endfunction

    function automatic logic [63:0] discount_of(logic [63:0] yy);
        logic [65:0] num;
        logic [65:0] d;
        logic [65:0] q;
        logic [65:0] r;
        num = 66'h1 << 64;
        d = 66'h1_0000_0000 + yy;
        q = num / d;
        r = num % d;
        if (2 * r >= d) q++;
        return q[63:0];
    endfunction

    function automatic logic [63:0] present_value(logic [63:0] yy);
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] v;
        logic [63:0] vf;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] sum;
        logic [63:0] k0;
        m = maturity_reg;
        if (m > (64'(MAX_YEARS) << FRAC_BITS)) m = 64'(MAX_YEARS) << FRAC_BITS;
        n = m >> FRAC_BITS;
        f = m & ((64'h1 << FRAC_BITS) - 1);
        v = discount_of(yy);
        vf = 64'h1_0000_0000;
        r = v;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            r = q32_root(r);
            if (f[FRAC_BITS-j]) vf = q32_mul(vf, r);
        end
        k0 = (f == 0) ? 1 : 0;
        p = 64'h1_0000_0000;
        sum = 0;
        for (longint unsigned k = 0; k <= n; k++) begin
            d = q32_mul(vf, p);
            if (k >= k0) sum += amount_scale(coupon_reg, d);
            if (k == n) sum += amount_scale(face_reg, d);
            p = q32_mul(p, v);
        end
        return sum;
    endfunction

    function automatic valuation_t value_bond(logic [31:0] yield_rate);
        valuation_t  e;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        p1 = present_value(yield_rate);
        p2 = present_value(64'(yield_rate) + 64'd42949673);
        e.duration = 0;
        e.zero = (p1 == 0);
        if (p1 != 0) begin
            num = ((p2 > p1) ? 64'd0 : p1 - p2) * 100;
            q = num / p1;
            rem = num % p1;
            if (q >= 64'h1_0000) begin
                e.duration = 32'hFFFF_FFFF;
            end else begin
                for (int i = 0; i < 16; i++) begin
                    rem <<= 1;
                    q <<= 1;
                    if (rem >= p1) begin
                        rem -= p1;
                        q |= 1;
                    end
                end
                if (2 * rem >= p1) q++;
                e.duration = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
        end
        e.price = (p1 > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : p1[39:0];
        return e;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        valuation_t e;
        s_fire <= s_tvalid && s_tready && aresetn;
        m_fire <= m_tvalid && m_tready && aresetn;
        if (aresetn && s_tvalid && s_tready)
            valuation_q.insert(valuation_q.size(), value_bond(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (valuation_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h %h", m_tdata, m_tuser);
            end else begin
                e = valuation_q.pop_front();
                if (m_tdata[39:0] !== e.price || m_tdata[71:40] !== e.duration
                        || m_tuser[0] !== e.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp price %h dur %h zero %b, got %h %h %b",
                                 e.price, e.duration, e.zero,
                                 m_tdata[39:0], m_tdata[71:40], m_tuser[0]);
                end
            end
        end
    end

    always @(negedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else if (!(s_tvalid && !s_fire)) begin
            nv = 1'b0;
            if (s_gap != 0) begin
                s_gap--;
            end else if (yield_q.size() != 0) begin
                s_tdata <= yield_q.pop_front();
                nv = 1'b1;
                s_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            s_tvalid <= nv;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_fire) m_stall = no_idle ? 0 : $urandom_range(0, 9);
            if (m_stall != 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(8 * idx);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FACE:   face_reg = value[39:0];
            REG_COUPON: coupon_reg = value[39:0];
            REG_MAT:    maturity_reg = value[22:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (yield_q.size() != 0 || valuation_q.size() != 0 || s_tvalid) @(posedge aclk);
    endtask

    task automatic set_bond(logic [39:0] face, logic [39:0] coupon, logic [22:0] maturity);
        drain();
        reg_write(REG_FACE, face);
        reg_write(REG_COUPON, coupon);
        reg_write(REG_MAT, maturity);
    endtask

    task automatic run_yields(int count);
        logic [31:0] y;
        yield_q.insert(yield_q.size(), 32'h0);
        yield_q.insert(yield_q.size(), 32'hFFFF_FFFF);
        yield_q.insert(yield_q.size(), 32'h8000_0000);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: y = $urandom_range(0, 32'h1000_0000);
                1: y = 32'hFFFF_FFFF - $urandom_range(0, 255);
                default: y = $urandom;
            endcase
            yield_q.insert(yield_q.size(), y);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        no_idle = 1'b0;
        face_reg = FACE_RST;
        coupon_reg = COUPON_RST;
        maturity_reg = MAT_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        yield_q.insert(yield_q.size(), 32'h0000_0001);
        yield_q.insert(yield_q.size(), 32'h0A3D_70A4);
        run_yields(200);
        set_bond(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 23'd4194304);
        run_yields(40);
        set_bond(40'd0, 40'd0, 23'd655360);
        run_yields(20);
        set_bond(40'd0, 40'd1, 23'd1);
        run_yields(100);
        no_idle = 1'b1;
        set_bond(40'd65536000, 40'd0, 23'h1_8000);
        run_yields(200);
        no_idle = 1'b0;
        set_bond(40'd1, 40'd0, 23'd4194303);
        run_yields(40);
        set_bond(40'hFF_FFFF_FFFF, 40'd0, 23'hFFFF);
        run_yields(100);
        for (int ph = 0; ph < 12; ph++) begin
            set_bond({$urandom, $urandom} & 40'hFF_FFFF_FFFF,
                     {$urandom, $urandom} & 40'hFF_FFFF_FFFF,
                     (ph % 3 == 0) ? 23'($urandom_range(1, 23'h7FFFFF) & 23'h3FFFFF | 23'h1)
                                   : 23'($urandom_range(1, 20 << 16)));
            no_idle = (ph % 4 == 1);
            run_yields(100);
        end
        drain();
        repeat (3000) @(posedge aclk);
        if (mismatches == 0 && valuation_q.size() == 0) begin
            $display("bond_price_and_duration verification clean");
        end else begin
            $display("bond_price_and_duration verification failed");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("bond_price_and_duration verification failed");
        $finish;
    end

endmodule
